@@ rtl/wpf_pkg.sv @@
// wpf_pkg: shared constants, types and helpers for the waveform peak finder
// no dependencies
package wpf_pkg;

	localparam int BLOCK_LENGTH = 256;
	localparam int MAX_PEAKS = 63;
	localparam int AW = $clog2(BLOCK_LENGTH);
	localparam int CW = AW + 1;
	localparam int SW = 24;
	localparam int NW = 28;
	localparam int SUMW = SW + CW + 5;
	localparam int QW = SUMW;

	localparam int REG_SIGMA = 0;
	localparam int REG_START = 1;

	localparam logic [0:0] KIND_PEAK = 1'b0;
	localparam logic [0:0] KIND_CLOSE = 1'b1;

	typedef struct packed {
		logic start;
		logic [SUMW-1:0] num;
		logic [CW-1:0] den;
	} div_req_t;

	function automatic logic [SW-1:0] abs_val(input logic signed [SW-1:0] v);
		abs_val = v[SW-1] ? SW'(-v) : v;
	endfunction

endpackage

@@ rtl/waveform_peak_finder.sv @@
// waveform_peak_finder: top level, sequencer around the sample memory
// depends on wpf_pkg, wpf_ram, wpf_div
//
// usage: samples enter on the in channel (valid/stall), one per cycle while
// loading; the sample flagged last_sample closes the block. samples beyond
// 256 are dropped but their last flag still closes the block.
// after the close the block stalls its input and runs from the sample memory:
// pass one sums |x|, a bit-serial divide, pass two sums the kept samples,
// a second divide, then the peak walk, which waits on the read data of each
// sample since each memory read is registered. the pace of a full block is set
// by the single read port of the sample memory and the serial divider, and the
// input stays stalled until the closing request of the current block is issued.
// results: up to 63 peak requests (kind 0) in index order, then one closing
// request (kind 1) carrying noise_level and peaks_dropped.
// the output is a register; while out_stall is high the walk pauses before its
// next request and the waiting request holds. reset clears control state and
// the registers to defaults; the sample memory is not cleared, only entries of
// the current block are read.
module waveform_peak_finder (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [23:0] sample,
	input logic last_sample,
	output logic out_valid,
	input logic out_stall,
	output logic [0:0] kind,
	output logic [7:0] peak_index,
	output logic signed [23:0] peak_value,
	output logic [27:0] noise_level,
	output logic peaks_dropped,
	output logic last_result
);
	localparam int AW = wpf_pkg::AW;
	localparam int CW = wpf_pkg::CW;
	localparam int SW = wpf_pkg::SW;
	localparam int SUMW = wpf_pkg::SUMW;
	localparam int NW_T = wpf_pkg::NW + 4;

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_P1 = 4'd1;
	localparam logic [3:0] ST_D1 = 4'd2;
	localparam logic [3:0] ST_P2 = 4'd3;
	localparam logic [3:0] ST_D2 = 4'd4;
	localparam logic [3:0] ST_RD = 4'd5;
	localparam logic [3:0] ST_CMP = 4'd6;
	localparam logic [3:0] ST_EMIT = 4'd7;
	localparam logic [3:0] ST_CLOSE = 4'd8;
	localparam logic [3:0] ST_WAIT = 4'd9;
	localparam logic [3:0] ST_THR = 4'd10;
	localparam logic [3:0] ST_WAIT2 = 4'd11;

	logic [15:0] sigma_q;
	logic [7:0] start_q;
	logic [3:0] st_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_q;
	logic rv_s1;
	logic [SUMW-1:0] sum_q;
	logic [CW-1:0] ign_q;
	logic [NW_T-1:0] n1_q;
	logic [27:0] noise_q;
	logic [43:0] thr_q;
	logic [5:0] pk_q;
	logic drop_q;
	logic climb_q;
	logic [CW-1:0] wi_q;
	logic signed [SW-1:0] cur_q;

	// memory
	logic we;
	logic [AW-1:0] raddr;
	logic signed [SW-1:0] rdata;
	wpf_pkg::div_req_t dreq;
	logic dbusy;
	logic [wpf_pkg::QW-1:0] dq;

	assign in_stall = st_q != ST_LOAD;
	assign we = in_valid && !in_stall && cnt_q < CW'(wpf_pkg::BLOCK_LENGTH);

	wpf_ram #(.WIDTH(SW), .DEPTH(wpf_pkg::BLOCK_LENGTH)) u_ram (
		.clk(clk), .we(we), .waddr(cnt_q[AW-1:0]), .wdata(sample),
		.raddr(raddr), .rdata(rdata)
	);

	wpf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quot(dq));

	assign raddr = rd_q[AW-1:0];

	logic [SW-1:0] a_s;
	logic [SW+4:0] a16;
	logic [NW_T+1:0] n1x3;
	assign a_s = wpf_pkg::abs_val(rdata);
	assign a16 = {1'b0, a_s, 4'b0};
	assign n1x3 = {2'b0, n1_q} + {1'b0, n1_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= 16'd1280;
			start_q <= 8'd100;
		end else if (cfg_we) begin
			if (cfg_index == 1'(wpf_pkg::REG_SIGMA)) begin
				sigma_q <= cfg_data;
			end else begin
				start_q <= cfg_data[7:0];
			end
		end
	end

	logic out_free;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = SUMW'(sum_q * 5) << 2;
		dreq.den = n_q - ign_q;
		if (st_q == ST_P1 && rd_q == n_q && !rv_s1) begin
			dreq.start = n_q != '0;
			dreq.den = n_q;
		end
		// a start index beyond the block still divides a zero sum
		if (st_q == ST_P2 && rd_q >= n_q && !rv_s1) begin
			dreq.start = (n_q - ign_q) != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			cnt_q <= '0;
			rv_s1 <= 1'b0;
			out_valid <= 1'b0;
			rd_q <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			rv_s1 <= 1'b0;
			unique case (st_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (we) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (last_sample) begin
							n_q <= we ? cnt_q + 1'b1 : cnt_q;
							cnt_q <= '0;
							rd_q <= '0;
							sum_q <= '0;
							ign_q <= '0;
							st_q <= ST_P1;
						end
					end
				end
				ST_P1: begin
					if (rd_q != n_q) begin
						rd_q <= rd_q + 1'b1;
						rv_s1 <= 1'b1;
					end
					if (rv_s1) begin
						sum_q <= sum_q + SUMW'(a_s);
					end
					if (rd_q == n_q && !rv_s1) begin
						st_q <= ST_D1;
					end
				end
				ST_D1: begin
					if (!dbusy) begin
						n1_q <= (n_q == '0) ? '0 : NW_T'(dq);
						sum_q <= '0;
						rd_q <= {1'b0, start_q};
						st_q <= ST_P2;
					end
				end
				ST_P2: begin
					if (rd_q < n_q) begin
						rd_q <= rd_q + 1'b1;
						rv_s1 <= 1'b1;
					end else begin
						rd_q <= n_q;
					end
					if (rv_s1) begin
						if ({{(NW_T-SW-3){1'b0}}, a16} < n1x3) begin
							sum_q <= sum_q + SUMW'(a_s);
						end else begin
							ign_q <= ign_q + 1'b1;
						end
					end
					if ((rd_q >= n_q) && !rv_s1) begin
						rd_q <= n_q;
						st_q <= ST_D2;
					end
				end
				ST_D2: begin
					if (!dbusy) begin
						noise_q <= ((n_q - ign_q) == '0) ? '0 : dq[27:0];
						st_q <= ST_THR;
					end
				end
				ST_THR: begin
					thr_q <= sigma_q * noise_q;
					pk_q <= '0;
					drop_q <= 1'b0;
					wi_q <= CW'(1);
					climb_q <= 1'b1;
					rd_q <= CW'(1);
					// the walk runs only while i < n-2, so at least four samples
					st_q <= (n_q >= CW'(4)) ? ST_RD : ST_CLOSE;
				end
				ST_RD: begin
					// read s[i], next cycle read s[i+1]
					rd_q <= wi_q + 1'b1;
					st_q <= ST_WAIT;
				end
				ST_WAIT: begin
					cur_q <= rdata;
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (climb_q) begin
						if (wi_q + CW'(2) < n_q && rdata > cur_q) begin
							wi_q <= wi_q + 1'b1;
							cur_q <= rdata;
							rd_q <= wi_q + CW'(2);
							st_q <= ST_WAIT2;
						end else begin
							st_q <= ST_EMIT;
						end
					end else begin
						if (wi_q + CW'(1) < n_q && cur_q > rdata) begin
							wi_q <= wi_q + 1'b1;
							cur_q <= rdata;
							rd_q <= wi_q + CW'(2);
							st_q <= ST_WAIT2;
						end else begin
							// next outer iteration: i++
							if (wi_q + CW'(1) < n_q - CW'(2)) begin
								wi_q <= wi_q + 1'b1;
								rd_q <= wi_q + 1'b1;
								climb_q <= 1'b1;
								st_q <= ST_RD;
							end else begin
								st_q <= ST_CLOSE;
							end
						end
					end
				end
				ST_WAIT2: begin
					st_q <= ST_CMP;
				end
				ST_EMIT: begin
					if ($signed({cur_q, 12'b0}) > $signed({1'b0, thr_q})) begin
						if (pk_q != 6'(wpf_pkg::MAX_PEAKS)) begin
							if (out_free) begin
								out_valid <= 1'b1;
								kind <= wpf_pkg::KIND_PEAK;
								peak_index <= wi_q[7:0];
								peak_value <= cur_q;
								noise_level <= '0;
								peaks_dropped <= 1'b0;
								last_result <= 1'b0;
								pk_q <= pk_q + 1'b1;
								climb_q <= 1'b0;
								rd_q <= wi_q + 1'b1;
								st_q <= ST_WAIT2;
							end
						end else begin
							drop_q <= 1'b1;
							climb_q <= 1'b0;
							rd_q <= wi_q + 1'b1;
							st_q <= ST_WAIT2;
						end
					end else begin
						climb_q <= 1'b0;
						rd_q <= wi_q + 1'b1;
						st_q <= ST_WAIT2;
					end
				end
				ST_CLOSE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						kind <= wpf_pkg::KIND_CLOSE;
						peak_index <= '0;
						peak_value <= '0;
						noise_level <= noise_q;
						peaks_dropped <= drop_q;
						last_result <= 1'b1;
						st_q <= ST_LOAD;
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

`ifndef SYNTH
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_LOAD |-> in_stall)
		else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(peak_index) && $stable(kind))
		else $error("stalled request changed");
	a_peak_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pk_q <= 6'(wpf_pkg::MAX_PEAKS))
		else $error("peak count over limit");
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == wpf_pkg::KIND_CLOSE) == last_result))
		else $error("closing request without last flag");
`endif
endmodule

@@ rtl/wpf_ram.sv @@
// wpf_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
module wpf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/wpf_div.sv @@
// wpf_div: restoring divider, one quotient bit per cycle
// depends on wpf_pkg
module wpf_div (
	input logic clk,
	input logic arst_n,
	input wpf_pkg::div_req_t req,
	output logic busy,
	output logic [wpf_pkg::QW-1:0] quot
);
	localparam int QW = wpf_pkg::QW;
	localparam int CW = wpf_pkg::CW;
	localparam int KW = $clog2(QW + 1);

	logic [QW-1:0] q_q;
	logic [CW-1:0] den_q;
	logic [CW:0] rem_q;
	logic [KW-1:0] cnt_q;
	logic [CW+1:0] trial;

	assign trial = {rem_q, q_q[QW-1]} - {1'b0, 1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= KW'(QW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (!trial[CW+1]) begin
				rem_q <= trial[CW:0];
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CW-1:0], q_q[QW-1]};
				q_q <= {q_q[QW-2:0], 1'b0};
			end
		end
	end

	assign busy = req.start || cnt_q != '0;
	assign quot = q_q;
endmodule
